/* design/pcba_pkg.sv */
// Package for the per-channel block averager: widths, table geometry,
// status and sequencer codes, and the slot entry layout.
// No dependencies.
package pcba_pkg;

  // Table geometry; the slot index is the low bits of the id, so depth is a power of two
  localparam int TABLE_DEPTH = 128;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);

  // Field widths; the sum holds up to 2047 full-scale samples of either sign
  localparam int ID_W     = 32;
  localparam int SAMPLE_W = 32;
  localparam int TIME_W   = 32;
  localparam int LEN_W    = 11;
  localparam int SUM_W    = 43;
  localparam int AVG_W    = 32;
  localparam int STATUS_W = 2;

  // Averaging length register
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);

  // Divider: one quotient bit per step over the whole sum
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCUM     = 2'd0,
    STAT_COLLISION = 2'd1,
    STAT_COMPLETE  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  // One slot of the table, kept in a single RAM word
  typedef struct packed {
    logic [ID_W-1:0]         owner;
    logic signed [SUM_W-1:0] sum;
    logic [TIME_W-1:0]       start;
    logic [LEN_W-1:0]        count;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

/* design/per_channel_block_averager_top.sv */
// Per-channel block averager top level: slot table, sequencer, serial divider.
// Depends on pcba_pkg and pcba_ram.

// Each input transaction (id, signed sample, timestamp) selects the slot given by
// the low bits of its id. An empty slot is claimed, a slot owned by another id
// drops the report with a collision status, and an owner's report is added in.
// When the sample count reaches the averaging length, the result carries the
// owner id, the sum divided by the length (truncated toward zero) and the
// seconds since the first sample, and the slot empties. Every input yields
// exactly one output transaction. An item is taken one at a time: a report that
// does not complete an average goes through accept, RAM read, update and result
// load; a completing report also passes through the one-bit-per-cycle restoring
// divider before the result load. The slot table lives in one RAM with a valid bit
// per slot in flops, so no clearing pass is needed after reset. Lengths 0 and 1
// act as 2.
module per_channel_block_averager_top (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration: averaging length
  input  logic                        cfg_wr_en,
  input  logic [pcba_pkg::LEN_W-1:0]  cfg_wr_data,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,  // source id, sample value, time seconds
  // Output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,  // owner id, average value, interval seconds
  output logic [pcba_pkg::STATUS_W-1:0] m_axis_tuser  // status
);

  pcba_pkg::state_t state, state_next;

  logic [pcba_pkg::LEN_W-1:0]    length_reg;
  logic [pcba_pkg::LEN_W-1:0]    eff_len;

  logic [pcba_pkg::TABLE_DEPTH-1:0] slot_valid;

  // Latched input item
  logic [pcba_pkg::ID_W-1:0]     item_id;
  logic [pcba_pkg::SAMPLE_W-1:0] item_sample;
  logic [pcba_pkg::TIME_W-1:0]   item_time;
  logic [pcba_pkg::SLOT_W-1:0]   slot;

  // Pending result
  pcba_pkg::status_t             res_status;
  logic [pcba_pkg::ID_W-1:0]     res_id;
  logic [pcba_pkg::TIME_W-1:0]   res_interval;

  // Divider
  logic [pcba_pkg::SUM_W-1:0]    div_quot;
  logic [pcba_pkg::LEN_W-1:0]    div_rem;
  logic [pcba_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          div_neg;
  logic [pcba_pkg::LEN_W:0]      div_shift;
  logic                          div_ge;

  // Table RAM
  logic                          ram_we;
  pcba_pkg::slot_entry_t         ram_wentry;
  logic [pcba_pkg::ENTRY_W-1:0]  ram_rdata;
  pcba_pkg::slot_entry_t         entry;

  // Slot evaluation
  logic                          hit_valid;
  logic                          owner_match;
  logic signed [pcba_pkg::SUM_W-1:0] sample_ext;
  logic signed [pcba_pkg::SUM_W-1:0] sum_new;
  logic [pcba_pkg::LEN_W-1:0]    cnt_new;
  logic                          completes;
  logic [pcba_pkg::AVG_W-1:0]    avg_mag;
  logic [pcba_pkg::AVG_W-1:0]    avg_out;
  logic                          out_load;

  assign eff_len = (length_reg < pcba_pkg::LEN_MIN) ? pcba_pkg::LEN_MIN : length_reg;

  assign s_axis_tready = (state == pcba_pkg::S_IDLE);

  // Slot table storage
  pcba_ram #(
    .DATA_W (pcba_pkg::ENTRY_W),
    .DEPTH  (pcba_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wentry),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign entry       = pcba_pkg::slot_entry_t'(ram_rdata);
  assign hit_valid   = slot_valid[slot];
  assign owner_match = (entry.owner == item_id);
  assign sample_ext  = {{(pcba_pkg::SUM_W-pcba_pkg::SAMPLE_W){item_sample[pcba_pkg::SAMPLE_W-1]}},
                        item_sample};
  assign sum_new     = entry.sum + sample_ext;
  assign cnt_new     = entry.count + pcba_pkg::LEN_W'(1);
  assign completes   = (cnt_new >= eff_len);

  // Restoring divider step on the magnitude
  assign div_shift = {div_rem, div_quot[pcba_pkg::SUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, eff_len});

  // Signed quotient, truncated toward zero
  assign avg_mag = div_quot[pcba_pkg::AVG_W-1:0];
  assign avg_out = div_neg ? (~avg_mag + pcba_pkg::AVG_W'(1)) : avg_mag;

  assign out_load = (state == pcba_pkg::S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Sequencer and table write control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wentry = '{owner: item_id, sum: sample_ext, start: item_time,
                   count: pcba_pkg::LEN_W'(1)};
    unique case (state)
      pcba_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = pcba_pkg::S_READ;
        end
      end
      pcba_pkg::S_READ: begin
        state_next = pcba_pkg::S_EVAL;
      end
      pcba_pkg::S_EVAL: begin
        state_next = pcba_pkg::S_DONE;
        if (!hit_valid) begin
          ram_we = 1'b1;
        end else if (owner_match) begin
          if (completes) begin
            state_next = pcba_pkg::S_DIV;
          end else begin
            ram_we     = 1'b1;
            ram_wentry = '{owner: entry.owner, sum: sum_new, start: entry.start,
                           count: cnt_new};
          end
        end
      end
      pcba_pkg::S_DIV: begin
        if (div_cnt == '0) begin
          state_next = pcba_pkg::S_DONE;
        end
      end
      pcba_pkg::S_DONE: begin
        if (out_load) begin
          state_next = pcba_pkg::S_IDLE;
        end
      end
      default: state_next = pcba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= pcba_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      length_reg <= cfg_wr_data;
    end
  end

  // Slot occupancy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (state == pcba_pkg::S_EVAL) begin
      if (!hit_valid) begin
        slot_valid[slot] <= 1'b1;
      end else if (owner_match && completes) begin
        slot_valid[slot] <= 1'b0;
      end
    end
  end

  // Item capture, evaluation results and divider
  always_ff @(posedge clk) begin
    if (state == pcba_pkg::S_IDLE && s_axis_tvalid) begin
      item_id     <= s_axis_tdata[31:0];
      item_sample <= s_axis_tdata[63:32];
      item_time   <= s_axis_tdata[95:64];
      slot        <= s_axis_tdata[pcba_pkg::SLOT_W-1:0];
    end

    if (state == pcba_pkg::S_EVAL) begin
      res_id       <= '0;
      res_interval <= '0;
      div_quot     <= '0;
      div_rem      <= '0;
      div_neg      <= 1'b0;
      div_cnt      <= pcba_pkg::DIV_CNT_W'(pcba_pkg::DIV_STEPS - 1);
      if (!hit_valid) begin
        res_status <= pcba_pkg::STAT_ACCUM;
      end else if (!owner_match) begin
        res_status <= pcba_pkg::STAT_COLLISION;
      end else if (completes) begin
        res_status   <= pcba_pkg::STAT_COMPLETE;
        res_id       <= entry.owner;
        res_interval <= item_time - entry.start;
        div_neg      <= sum_new[pcba_pkg::SUM_W-1];
        div_quot     <= sum_new[pcba_pkg::SUM_W-1] ? (~sum_new + pcba_pkg::SUM_W'(1))
                                                   : sum_new;
      end else begin
        res_status <= pcba_pkg::STAT_ACCUM;
      end
    end

    // One quotient bit per cycle
    if (state == pcba_pkg::S_DIV) begin
      div_quot <= {div_quot[pcba_pkg::SUM_W-2:0], div_ge};
      div_rem  <= div_ge ? pcba_pkg::LEN_W'(div_shift - {1'b0, eff_len})
                         : div_shift[pcba_pkg::LEN_W-1:0];
      div_cnt  <= div_cnt - pcba_pkg::DIV_CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser        <= res_status;
      m_axis_tdata[31:0]  <= res_id;
      m_axis_tdata[63:32] <= (res_status == pcba_pkg::STAT_COMPLETE) ? avg_out : '0;
      m_axis_tdata[95:64] <= res_interval;
    end
  end

endmodule

/* design/pcba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcba_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/tb_top.sv */
// Testbench for per_channel_block_averager_top: a scoreboard class predicts
// each result from its own slot table, and plain tasks drive the input stream.
// Depends on pcba_pkg and the design files.
module tb_top;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLE = 60;   // beyond the completing path
  localparam int POOL_SIZE    = 5;
  localparam logic [pcba_pkg::ID_W-1:0] SLOT_MASK =
    pcba_pkg::ID_W'(pcba_pkg::TABLE_DEPTH - 1);

  // One expected output transaction
  typedef struct {
    pcba_pkg::status_t               status;
    logic [pcba_pkg::ID_W-1:0]       owner_id;
    logic [pcba_pkg::AVG_W-1:0]      average;
    logic [pcba_pkg::TIME_W-1:0]     interval;
  } avg_result_t;

  // Slot table predictor plus the queue of averages still owed by the block
  class averager_scoreboard;
    logic [pcba_pkg::LEN_W-1:0]  length_reg;
    logic [pcba_pkg::LEN_W-1:0]  slot_count [pcba_pkg::TABLE_DEPTH];
    logic [pcba_pkg::ID_W-1:0]   slot_owner [pcba_pkg::TABLE_DEPTH];
    longint                      slot_sum   [pcba_pkg::TABLE_DEPTH];
    logic [pcba_pkg::TIME_W-1:0] slot_start [pcba_pkg::TABLE_DEPTH];
    avg_result_t                 owed_results [$];
    int errors, reports, completions, collisions;

    function new();
      length_reg = pcba_pkg::LEN_RESET;
      foreach (slot_count[i]) begin
        slot_count[i] = '0;
      end
      errors = 0;
      reports = 0;
      completions = 0;
      collisions = 0;
    endfunction

    function void write_length(logic [pcba_pkg::LEN_W-1:0] value);
      length_reg = value;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Predict the result of one accepted report
    function void accept_report(logic [pcba_pkg::ID_W-1:0] id,
                                logic signed [pcba_pkg::SAMPLE_W-1:0] sample_in,
                                logic [pcba_pkg::TIME_W-1:0] stamp);
      int unsigned                slot;
      logic [pcba_pkg::LEN_W-1:0] eff_len;
      longint                     quotient;
      avg_result_t                res;
      slot = id % pcba_pkg::TABLE_DEPTH;
      eff_len = (length_reg < pcba_pkg::LEN_MIN) ? pcba_pkg::LEN_MIN : length_reg;
      res.status = pcba_pkg::STAT_ACCUM;
      res.owner_id = '0;
      res.average = '0;
      res.interval = '0;
      reports++;
      if (slot_count[slot] == '0) begin
        // empty slot is claimed by this id
        slot_owner[slot] = id;
        slot_sum[slot] = longint'(sample_in);
        slot_start[slot] = stamp;
        slot_count[slot] = pcba_pkg::LEN_W'(1);
      end else if (slot_owner[slot] != id) begin
        res.status = pcba_pkg::STAT_COLLISION;
        collisions++;
      end else begin
        slot_sum[slot] += longint'(sample_in);
        slot_count[slot] = slot_count[slot] + 1'b1;
        if (slot_count[slot] >= eff_len) begin
          // signed 64-bit division truncates toward zero
          quotient = slot_sum[slot] / longint'(eff_len);
          res.status = pcba_pkg::STAT_COMPLETE;
          res.owner_id = slot_owner[slot];
          res.average = quotient[pcba_pkg::AVG_W-1:0];
          res.interval = stamp - slot_start[slot];
          slot_count[slot] = '0;
          completions++;
        end
      end
      owed_results.push_back(res);
    endfunction

    // Compare one output transaction with the oldest owed result
    function void check_result(logic [pcba_pkg::STATUS_W-1:0] status_bits, logic [95:0] data);
      avg_result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result: status %0d, data %h", status_bits, data);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (status_bits !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status_bits);
        errors++;
      end
      if (data[31:0] !== want.owner_id) begin
        $error("owner_id: expected %h, actual %h", want.owner_id, data[31:0]);
        errors++;
      end
      if (data[63:32] !== want.average) begin
        $error("average_value: expected %0d, actual %0d",
               $signed(want.average), $signed(data[63:32]));
        errors++;
      end
      if (data[95:64] !== want.interval) begin
        $error("interval_seconds: expected %0d, actual %0d", want.interval, data[95:64]);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [pcba_pkg::LEN_W-1:0]    cfg_wr_data = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [95:0]                   s_axis_tdata = '0;  // source id, sample value, time seconds
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [95:0]                   m_axis_tdata;       // owner id, average value, interval seconds
  logic [pcba_pkg::STATUS_W-1:0] m_axis_tuser;       // status

  averager_scoreboard          sb = new();
  bit                          tx_idle_on = 1'b1;
  bit                          rx_idle_on = 1'b1;
  int                          stall_left = 0;
  int                          cycle_count = 0;
  int                          length_writes = 0;
  logic [pcba_pkg::ID_W-1:0]   probe_pool [POOL_SIZE];
  logic [pcba_pkg::TIME_W-1:0] clock_now;

  per_channel_block_averager_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Output side: random stalls on tready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
      stall_left <= gap_length() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one report, with an optional gap in front of it
  task automatic send_report(logic [pcba_pkg::ID_W-1:0] id,
                             logic signed [pcba_pkg::SAMPLE_W-1:0] sample_in,
                             logic [pcba_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 35) ? gap_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {stamp, sample_in, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.accept_report(id, sample_in, stamp);
  endtask

  // Hold the input until every owed result has come out
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Averaging length write, only with the block idle
  task automatic write_length(logic [pcba_pkg::LEN_W-1:0] value);
    drain_reports();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_length(value);
    length_writes++;
  endtask

  // Random reports: mostly a small pool of repeating ids, some of them sharing a slot
  task automatic run_random_phase(int n_reports);
    logic [pcba_pkg::ID_W-1:0]            id;
    logic signed [pcba_pkg::SAMPLE_W-1:0] value;
    int                                   r;
    int                                   j;
    for (int k = 0; k < POOL_SIZE; k++) begin
      if ($urandom_range(0, 1) == 1) begin
        if (k > 0 && $urandom_range(0, 2) == 0) begin
          j = $urandom_range(0, k - 1);
          probe_pool[k] = ($urandom & ~SLOT_MASK) | (probe_pool[j] & SLOT_MASK);
          if (probe_pool[k] == probe_pool[j]) probe_pool[k] ^= 32'h8000_0000;
        end else begin
          probe_pool[k] = $urandom;
        end
      end
    end
    if ($urandom_range(0, 3) == 0) clock_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
    else clock_now = $urandom;
    for (int i = 0; i < n_reports; i++) begin
      if ($urandom_range(0, 49) == 0) drain_reports();
      r = $urandom_range(0, 99);
      if (r < 94) begin
        id = probe_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 97) begin
        // stray id aimed at a pool slot
        id = ($urandom & ~SLOT_MASK) | (probe_pool[$urandom_range(0, POOL_SIZE - 1)] & SLOT_MASK);
      end else begin
        id = $urandom;
      end
      r = $urandom_range(0, 99);
      if (r < 5) value = 32'sh7FFF_FFFF;
      else if (r < 10) value = 32'sh8000_0000;
      else if (r < 30) value = $urandom_range(0, 200) - 100;
      else value = $urandom;
      clock_now += $urandom_range(0, 9);
      if ($urandom_range(0, 49) == 0) clock_now = $urandom;
      send_report(id, value, clock_now);
    end
  endtask

  // Main sequence
  initial begin
    int phase_lengths [12] = '{2047, 2, 3, 1024, 5, 16, 1, 4, 7, 0, 10, 2};
    foreach (probe_pool[k]) probe_pool[k] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset length of 10: full-scale positive samples, a colliding id midway,
    // timestamps wrapping past 2^32
    for (int i = 0; i < 10; i++) begin
      if (i == 4) send_report(32'h0000_007F, 32'sh0, 32'h0000_1234);
      send_report(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFA + i);
    end

    // Length 0 acts as 2: most negative samples, widest interval, rounding toward zero
    write_length(pcba_pkg::LEN_W'(0));
    send_report(32'h0000_0000, 32'sh8000_0000, 32'h0000_0000);
    send_report(32'h0000_0000, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_report(32'h0000_0005, -32'sd3, 32'd100);
    send_report(32'h0000_0005, 32'sd0, 32'd100);

    // Length lowered while a sensor is part way: next report completes it
    write_length(pcba_pkg::LEN_W'(10));
    send_report(32'h0000_0007, 32'sd1000, 32'd10);
    send_report(32'h0000_0007, -32'sd1, 32'd20);
    send_report(32'h0000_0007, 32'sd7, 32'd30);
    write_length(pcba_pkg::LEN_W'(1));
    send_report(32'h0000_0007, 32'sd2, 32'd40);

    // Length raised while a sensor is part way: accumulation runs to the new length
    write_length(pcba_pkg::LEN_W'(2));
    send_report(32'h0000_0009, -32'sd5, 32'd0);
    write_length(pcba_pkg::LEN_W'(4));
    send_report(32'h0000_0009, -32'sd5, 32'd1);
    send_report(32'h0000_0009, -32'sd5, 32'd2);
    send_report(32'h0000_0009, -32'sd6, 32'd3);

    // Random phases over a range of lengths, idling switched per phase
    foreach (phase_lengths[p]) begin
      write_length(pcba_pkg::LEN_W'(phase_lengths[p]));
      tx_idle_on = (p == 0) || (p != 4 && $urandom_range(0, 3) != 0);
      rx_idle_on <= (p == 0) || (p != 4 && $urandom_range(0, 3) != 0);
      run_random_phase(phase_lengths[p] >= 1000 ? 30 : 62);
    end

    drain_reports();
    repeat (SETTLE_CYCLE) @(posedge clk);
    $display("Covered %0d reports: %0d averages completed, %0d collisions, %0d length writes",
             sb.reports, sb.completions, sb.collisions, length_writes);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
